// ===== design/pida_pkg.sv =====
package pida_pkg;

   localparam int POOL_WORDS_DEF = 2048;
   localparam int GROW_STEP_DEF  = 4;

   localparam int ID_W       = 16;
   localparam int DATA_W     = 32;
   localparam int BIT_W      = 5;
   localparam int WORD_IDX_W = ID_W - BIT_W;
   localparam int CMP_W      = WORD_IDX_W + 1;

   // Bit 31 of this word would be identifier 65536, which does not exist.
   localparam logic [WORD_IDX_W-1:0] TOP_WORD = '1;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_NOP     = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_BEYOND = 2'd2,
      STAT_FREE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      UOP_TEST_SET   = 2'd0,
      UOP_FIRST_FREE = 2'd1,
      UOP_CLEAR      = 2'd2
   } word_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FAST,
      ST_SCAN,
      ST_REL,
      ST_GROW,
      ST_DONE
   } state_type;

   typedef struct packed {
      word_op_type      op;
      logic [BIT_W-1:0] bit_sel;
      logic             top_word;
   } word_cmd_type;

   typedef struct packed {
      logic              hit;
      logic [BIT_W-1:0]  bit_idx;
      logic [DATA_W-1:0] new_word;
   } word_res_type;

   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] granted_id;
      status_type      status;
   } result_type;

endpackage

// ===== design/pida_ifs.sv =====
interface pida_req_if;
   import pida_pkg::*;
   logic            valid;
   logic            ready;
   logic [1:0]      command;
   logic [ID_W-1:0] id;

   modport source (output valid, output command, output id, input ready);
   modport sink   (input valid, input command, input id, output ready);
endinterface

interface pida_rsp_if;
   import pida_pkg::*;
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] granted_id;
   logic [1:0]      status;

   modport source (output valid, output granted_id, output status, input ready);
   modport sink   (input valid, input granted_id, input status, output ready);
endinterface

// ===== design/packet_id_bitmap_allocator_top.sv =====
// Bitmap identifier allocator. Identifier n lives in bit (n-1)%32 of word (n-1)/32.
// The req channel carries one word per command: allocate, release of req id, clear,
// or no operation. The rsp channel returns exactly one word per command with the
// granted identifier (zero unless an allocate succeeds) and a status code.
// A new command is taken only while the sequencer is idle; a finished result waits
// in an output register, so the next command can start while it is unread.
// Between acceptance and the rsp word the sequencer spends steps as follows: no
// step for clear, no operation, a release beyond the region or an allocate that
// fails at once; one for an in-region release or a fast-path allocate test; one
// per active word scanned (bitmap read port, one word per cycle through the shared
// bit-search unit); GROW_STEP steps of writes on the memory write port for growth.
// The next command is accepted in the idle state that follows the registering of
// a result, so the block takes one command at a time.
// Reset and clear empty the active region and need no clearing pass: each word is
// zeroed when the region grows over it. If the receiver stalls, the block finishes
// the command in hand and then holds its result until the output register frees.
module packet_id_bitmap_allocator_top
   import pida_pkg::*;
#(
   parameter int POOL_WORDS = POOL_WORDS_DEF,
   parameter int GROW_STEP  = GROW_STEP_DEF
) (
   input logic         clock,
   input logic         reset,
   pida_req_if.sink    req_bus,
   pida_rsp_if.source  rsp_bus
);

   localparam int ADDR_W = $clog2(POOL_WORDS);

   result_type        result;
   logic              out_free;
   word_cmd_type      unit_cmd;
   word_res_type      unit_res;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   logic              out_valid_ff, out_valid_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   status_type        out_status_ff, out_status_in;

   pida_ctrl #(
      .POOL_WORDS (POOL_WORDS),
      .GROW_STEP  (GROW_STEP)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .result      (result),
      .out_free    (out_free),
      .unit_cmd    (unit_cmd),
      .unit_res    (unit_res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr)
   );

   pida_word_unit u_word_unit (
      .cmd  (unit_cmd),
      .word (ram_rd_data),
      .res  (unit_res)
   );

   pida_ram #(
      .WIDTH (DATA_W),
      .DEPTH (POOL_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_id_in     = out_id_ff;
      out_status_in = out_status_ff;
      if (result.valid) begin
         out_valid_in  = 1'b1;
         out_id_in     = result.granted_id;
         out_status_in = result.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_id_ff     <= out_id_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.granted_id = out_id_ff;
   assign rsp_bus.status     = out_status_ff;

endmodule

// ===== design/pida_ram.sv =====
module pida_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pida_word_unit.sv =====
module pida_word_unit
   import pida_pkg::*;
(
   input  word_cmd_type      cmd,
   input  logic [DATA_W-1:0] word,
   output word_res_type      res
);

   logic [DATA_W-1:0] free_mask;
   logic [DATA_W-1:0] lowest;
   logic [DATA_W-1:0] sel_mask;
   logic [BIT_W-1:0]  low_idx;

   always_comb begin
      free_mask = ~word;
      if (cmd.top_word) begin
         free_mask[DATA_W-1] = 1'b0;
      end
      // Two's complement trick isolates the lowest free bit.
      lowest  = free_mask & (~free_mask + DATA_W'(1));
      low_idx = '0;
      for (int i = 0; i < DATA_W; i++) begin
         if (lowest[i]) begin
            low_idx = low_idx | BIT_W'(i);
         end
      end
      sel_mask = DATA_W'(1) << cmd.bit_sel;
   end

   always_comb begin
      case (cmd.op)
         UOP_TEST_SET: begin
            res.hit      = ~word[cmd.bit_sel];
            res.bit_idx  = cmd.bit_sel;
            res.new_word = word | sel_mask;
         end
         UOP_FIRST_FREE: begin
            res.hit      = |free_mask;
            res.bit_idx  = low_idx;
            res.new_word = word | lowest;
         end
         UOP_CLEAR: begin
            res.hit      = word[cmd.bit_sel];
            res.bit_idx  = cmd.bit_sel;
            res.new_word = word & ~sel_mask;
         end
         default: begin
            res.hit      = 1'b0;
            res.bit_idx  = cmd.bit_sel;
            res.new_word = word;
         end
      endcase
   end

endmodule

// ===== design/pida_ctrl.sv =====
module pida_ctrl
   import pida_pkg::*;
#(
   parameter int POOL_WORDS = POOL_WORDS_DEF,
   parameter int GROW_STEP  = GROW_STEP_DEF,
   localparam int ADDR_W = $clog2(POOL_WORDS),
   localparam int ACT_W  = $clog2(POOL_WORDS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   pida_req_if.sink           req,
   output result_type         result,
   input  logic               out_free,
   output word_cmd_type       unit_cmd,
   input  word_res_type       unit_res,
   output logic               ram_wr_en,
   output logic [ADDR_W-1:0]  ram_wr_addr,
   output logic [DATA_W-1:0]  ram_wr_data,
   output logic [ADDR_W-1:0]  ram_rd_addr
);

   localparam int SUM_W = $clog2(POOL_WORDS + GROW_STEP + 1);
   localparam int GK_W  = (GROW_STEP > 1) ? $clog2(GROW_STEP) : 1;

   state_type         state_ff, state_in;
   logic [ACT_W-1:0]  active_ff, active_in;
   logic [ID_W-1:0]   last_ff, last_in;
   logic [ID_W-1:0]   target_ff, target_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic [GK_W-1:0]   grow_ff, grow_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   status_type        res_status_ff, res_status_in;

   logic            accept;
   command_type     cmd;
   logic [ID_W-1:0] cand;
   logic [ID_W-1:0] id_m1;
   logic [ID_W-1:0] tgt_m1;
   logic            cand_active;
   logic            rel_active;
   logic            grow_ok;
   logic            scan_more;
   logic            grow_last;
   logic [ID_W-1:0] scan_id;
   logic [ID_W-1:0] grow_id;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign cmd       = command_type'(req.command);

   assign cand   = (last_ff == '1) ? ID_W'(1) : last_ff + ID_W'(1);
   assign id_m1  = req.id - ID_W'(1);
   assign tgt_m1 = target_ff - ID_W'(1);

   // The word of the candidate is last_ff itself shifted, since cand - 1 == last_ff,
   // except on wrap, where the candidate is identifier 1 in word zero.
   assign cand_active = (last_ff == '1) ? (active_ff != '0) :
                        (CMP_W'(last_ff[ID_W-1:BIT_W]) < CMP_W'(active_ff));
   assign rel_active  = (req.id != '0) &&
                        (CMP_W'(id_m1[ID_W-1:BIT_W]) < CMP_W'(active_ff));
   assign grow_ok     = SUM_W'(active_ff) + SUM_W'(GROW_STEP) <= SUM_W'(POOL_WORDS);
   assign scan_more   = ACT_W'(scan_ff) + ACT_W'(1) < active_ff;
   assign grow_last   = (grow_ff == GK_W'(GROW_STEP - 1));
   assign scan_id     = {WORD_IDX_W'(scan_ff), unit_res.bit_idx} + ID_W'(1);
   assign grow_id     = {WORD_IDX_W'(active_ff), BIT_W'(0)} + ID_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= '0;
         last_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      scan_ff       <= scan_in;
      grow_ff       <= grow_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_ALLOC: begin
                     if (cand_active) begin
                        state_in = ST_FAST;
                     end else if (active_ff != '0) begin
                        state_in = ST_SCAN;
                     end else if (grow_ok) begin
                        state_in = ST_GROW;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  CMD_RELEASE: state_in = rel_active ? ST_REL : ST_DONE;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_FAST: state_in = unit_res.hit ? ST_DONE : ST_SCAN;
         ST_SCAN: begin
            if (unit_res.hit) begin
               state_in = ST_DONE;
            end else if (scan_more) begin
               state_in = ST_SCAN;
            end else if (grow_ok) begin
               state_in = ST_GROW;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REL:  state_in = ST_DONE;
         ST_GROW: state_in = grow_last ? ST_DONE : ST_GROW;
         ST_DONE: state_in = out_free ? ST_IDLE : ST_DONE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      active_in     = active_ff;
      last_in       = last_ff;
      target_in     = target_ff;
      scan_in       = scan_ff;
      grow_in       = grow_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;

      unit_cmd.op       = UOP_FIRST_FREE;
      unit_cmd.bit_sel  = tgt_m1[BIT_W-1:0];
      unit_cmd.top_word = (WORD_IDX_W'(scan_ff) == TOP_WORD);

      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_W'(tgt_m1[ID_W-1:BIT_W]);
      ram_wr_data = unit_res.new_word;
      ram_rd_addr = '0;

      result.valid      = 1'b0;
      result.granted_id = res_id_ff;
      result.status     = res_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_id_in     = '0;
               res_status_in = STAT_OK;
               scan_in       = '0;
               grow_in       = '0;
               case (cmd)
                  CMD_ALLOC: begin
                     target_in = cand;
                     if (cand_active) begin
                        ram_rd_addr = ADDR_W'(last_ff[ID_W-1:BIT_W] &
                                              {WORD_IDX_W{last_ff != '1}});
                     end else if (active_ff == '0 && !grow_ok) begin
                        res_status_in = STAT_FULL;
                        last_in       = '0;
                     end
                  end
                  CMD_RELEASE: begin
                     target_in   = req.id;
                     ram_rd_addr = ADDR_W'(id_m1[ID_W-1:BIT_W]);
                     if (!rel_active) begin
                        res_status_in = STAT_BEYOND;
                     end
                  end
                  CMD_CLEAR: begin
                     // Words are zeroed as the region grows over them, so
                     // emptying the region is enough.
                     active_in = '0;
                     last_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_FAST: begin
            unit_cmd.op = UOP_TEST_SET;
            if (unit_res.hit) begin
               ram_wr_en = 1'b1;
               res_id_in = target_ff;
               last_in   = target_ff;
            end
         end
         ST_SCAN: begin
            ram_wr_addr = scan_ff;
            if (unit_res.hit) begin
               ram_wr_en = 1'b1;
               res_id_in = scan_id;
               last_in   = scan_id;
            end else if (scan_more) begin
               scan_in     = scan_ff + ADDR_W'(1);
               ram_rd_addr = scan_ff + ADDR_W'(1);
            end else if (!grow_ok) begin
               res_status_in = STAT_FULL;
               last_in       = '0;
            end
         end
         ST_REL: begin
            unit_cmd.op = UOP_CLEAR;
            if (unit_res.hit) begin
               ram_wr_en = 1'b1;
            end else begin
               res_status_in = STAT_FREE;
            end
         end
         ST_GROW: begin
            // The first new word already carries the grant of its bit 0.
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(SUM_W'(active_ff) + SUM_W'(grow_ff));
            ram_wr_data = (grow_ff == '0) ? DATA_W'(1) : '0;
            grow_in     = grow_ff + GK_W'(1);
            if (grow_last) begin
               active_in = ACT_W'(SUM_W'(active_ff) + SUM_W'(GROW_STEP));
               res_id_in = grow_id;
               last_in   = grow_id;
            end
         end
         ST_DONE: begin
            result.valid = out_free;
         end
         default: ;
      endcase
   end

endmodule
